FILE: src/plsf_pkg.sv
// ----------------------------------------------------------------------------
// plsf_pkg: shared types and constants for the per-LED sine fade-out
// Field layout of the request and response words, the fade table entry,
// fixed-point constants of the sine gain and the Taylor divisor tables.
// ----------------------------------------------------------------------------
`default_nettype none

package plsf_pkg;

   // Tick counters and fraction resolution
   localparam int TIME_W      = 32;
   localparam int FRAC_W      = 10;
   localparam int GAIN_W      = 13;
   localparam int CHAN_W      = 8;

   // pi/2 in Q30 and unity gain
   localparam logic [30:0]       PI_HALF_Q30 = 31'd1686629713;
   localparam logic [GAIN_W-1:0] GAIN_ONE    = 13'd4096;

   // Request kinds (tuser)
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_EXEC  = 1'b1;

   // Request tdata layout, lowest bit first
   localparam int LED_LO     = 0;
   localparam int LED_W      = 16;
   localparam int PERIOD_LO  = LED_LO + LED_W;
   localparam int NOW_LO     = PERIOD_LO + TIME_W;
   localparam int RED_LO     = NOW_LO + TIME_W;
   localparam int GREEN_LO   = RED_LO + CHAN_W;
   localparam int BLUE_LO    = GREEN_LO + CHAN_W;
   localparam int REQ_DATA_W = BLUE_LO + CHAN_W;

   // Response tdata layout: red, green, blue
   localparam int RSP_DATA_W = 3 * CHAN_W;

   // One fade table entry
   typedef struct packed {
      logic [TIME_W-1:0] last_tick;
      logic [TIME_W-1:0] period_ticks;
      logic [TIME_W-1:0] remaining_ticks;
   } fade_entry_type;

   // Taylor term divisor (2k)(2k+1) for k = 1..7
   function automatic logic [7:0] divisor_of(input logic [2:0] k);
      logic [7:0] d;
      case (k)
         3'd1:    d = 8'd6;
         3'd2:    d = 8'd20;
         3'd3:    d = 8'd42;
         3'd4:    d = 8'd72;
         3'd5:    d = 8'd110;
         3'd6:    d = 8'd156;
         3'd7:    d = 8'd210;
         default: d = 8'd6;
      endcase
      return d;
   endfunction

   // floor(2^32 / divisor), the reciprocal for the quotient estimate
   function automatic logic [29:0] recip_of(input logic [2:0] k);
      logic [29:0] m;
      case (k)
         3'd1:    m = 30'd715827882;
         3'd2:    m = 30'd214748364;
         3'd3:    m = 30'd102261126;
         3'd4:    m = 30'd59652323;
         3'd5:    m = 30'd39045157;
         3'd6:    m = 30'd27531841;
         3'd7:    m = 30'd20452225;
         default: m = 30'd715827882;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

FILE: src/per_led_sine_fade_out.sv
// ----------------------------------------------------------------------------
// per_led_sine_fade_out: per-LED sine-shaped brightness fade
// Keeps a fade table per LED and scales colour requests by a sine gain of
// the remaining fade fraction.
// ----------------------------------------------------------------------------
// A start request (tuser = 0) loads an LED's remaining time and period and
// stamps the current tick; it gives no response. An execute request
// (tuser = 1) ages the entry by the elapsed ticks, forms the 10-bit fraction
// remaining/period and returns the colour scaled by a gain of about
// 4096*sin(fraction*pi/2), 4096 being unity. For an LED in range the
// fraction is divided out one bit per cycle, a step skipped when the
// remaining time is not below the period, and the sine series and the three
// colour products then run through a single shared 32x32 multiplier, each
// series term passing through the term, reciprocal, correction and fix
// states. A zero period gives black, and an LED index at or above LED_COUNT
// passes the colour through. An unread earlier response holding the output
// register delays the colour scaling. The block takes one request at a
// time; a finished response may wait in the output register while the next
// request is accepted. After reset the fade table is cleared in a pass over
// all LED_COUNT entries during which no request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module per_led_sine_fade_out #(
   parameter int LED_COUNT = 16
) (
   input  wire                                logic clock,
   input  wire                                logic reset,
   // Request channel
   input  wire                                logic req_tvalid,
   output logic                               req_tready,
   // led_index[15:0], fade_period[47:16], now_time[79:48],
   // red_in[87:80], green_in[95:88], blue_in[103:96]
   input  wire logic [plsf_pkg::REQ_DATA_W-1:0] req_tdata,
   // kind[0]
   input  wire                                logic req_tuser,
   // Response channel
   output logic                               rsp_tvalid,
   input  wire                                logic rsp_tready,
   // red_out[7:0], green_out[15:8], blue_out[23:16]
   output logic [plsf_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   import plsf_pkg::*;

   localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

   // Sequencer states
   localparam logic [4:0] ST_CLEAR   = 5'd0;
   localparam logic [4:0] ST_IDLE    = 5'd1;
   localparam logic [4:0] ST_FETCH   = 5'd2;
   localparam logic [4:0] ST_UPDATE  = 5'd3;
   localparam logic [4:0] ST_RANGE   = 5'd4;
   localparam logic [4:0] ST_DIV     = 5'd5;
   localparam logic [4:0] ST_ANGLE   = 5'd6;
   localparam logic [4:0] ST_ROUND   = 5'd7;
   localparam logic [4:0] ST_SQUARE  = 5'd8;
   localparam logic [4:0] ST_SQSAVE  = 5'd9;
   localparam logic [4:0] ST_TERM    = 5'd10;
   localparam logic [4:0] ST_RECIP   = 5'd11;
   localparam logic [4:0] ST_CORR    = 5'd12;
   localparam logic [4:0] ST_FIX     = 5'd13;
   localparam logic [4:0] ST_GAIN    = 5'd14;
   localparam logic [4:0] ST_OUTWAIT = 5'd15;
   localparam logic [4:0] ST_MUL_R   = 5'd16;
   localparam logic [4:0] ST_MUL_G   = 5'd17;
   localparam logic [4:0] ST_MUL_B   = 5'd18;
   localparam logic [4:0] ST_MUL_END = 5'd19;

   // Request fields
   logic [LED_W-1:0]  req_led;
   logic [TIME_W-1:0] req_period;
   logic [TIME_W-1:0] req_now;
   logic              req_in_range;
   logic              req_accept;

   // Control and datapath registers
   logic [4:0]          state_ff,  state_in;
   logic [IDX_W-1:0]    clr_ff,    clr_in;
   logic [IDX_W-1:0]    idx_ff,    idx_in;
   logic [TIME_W-1:0]   now_ff,    now_in;
   logic [CHAN_W-1:0]   red_ff,    red_in;
   logic [CHAN_W-1:0]   green_ff,  green_in;
   logic [CHAN_W-1:0]   blue_ff,   blue_in;
   logic [TIME_W-1:0]   diff_ff,   diff_in;
   logic [TIME_W-1:0]   rem_ff,    rem_in;
   logic [TIME_W-1:0]   per_ff,    per_in;
   logic [FRAC_W:0]     q_ff,      q_in;
   logic [3:0]          step_ff,   step_in;
   logic [30:0]         x_ff,      x_in;
   logic [31:0]         x2_ff,     x2_in;
   logic [30:0]         term_ff,   term_in;
   logic [31:0]         sum_ff,    sum_in;
   logic [31:0]         n_ff,      n_in;
   logic [29:0]         qe_ff,     qe_in;
   logic [GAIN_W-1:0]   gain_ff,   gain_in;
   logic [63:0]         prod_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]   rsp_red_ff,   rsp_red_in;
   logic [CHAN_W-1:0]   rsp_green_ff, rsp_green_in;
   logic [CHAN_W-1:0]   rsp_blue_ff,  rsp_blue_in;

   // Shared multiplier operands
   logic        mul_en;
   logic [31:0] mul_a;
   logic [31:0] mul_b;

   // Fade table ports
   fade_entry_type      mem [0:LED_COUNT-1];
   fade_entry_type      rd_ff;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_wa;
   fade_entry_type      mem_wd;
   logic                mem_re;

   // Helpers
   logic [TIME_W:0]   age_diff;
   logic [TIME_W:0]   div_trial;
   logic [41:0]       angle_rnd;
   logic [31:0]       corr_rem;
   logic [29:0]       corr_q;
   logic [32:0]       gain_rnd;
   logic [14:0]       gain_raw;
   logic              slot_free;

   assign req_led    = req_tdata[LED_LO +: LED_W];
   assign req_period = req_tdata[PERIOD_LO +: TIME_W];
   assign req_now    = req_tdata[NOW_LO +: TIME_W];
   assign req_in_range = (req_led < LED_W'(LED_COUNT));
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_blue_ff, rsp_green_ff, rsp_red_ff};

   // Arithmetic helpers for the sequencer
   assign age_diff  = {1'b0, rem_ff} - {1'b0, diff_ff};
   assign div_trial = {rem_ff, 1'b0} - {1'b0, per_ff};
   assign angle_rnd = prod_ff[41:0] + 42'd512;
   assign corr_rem  = n_ff - prod_ff[31:0];
   assign corr_q    = qe_ff + 30'(corr_rem >= {24'd0, divisor_of(step_ff[2:0])});
   assign gain_rnd  = {1'b0, sum_ff} + 33'd131072;
   assign gain_raw  = gain_rnd[32:18];

   // Multiplier operand select
   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      case (state_ff)
         ST_ANGLE: begin
            mul_a = {21'd0, q_ff};
            mul_b = {1'b0, PI_HALF_Q30};
         end
         ST_SQUARE: begin
            mul_a = {1'b0, x_ff};
            mul_b = {1'b0, x_ff};
         end
         ST_TERM: begin
            mul_a = {1'b0, term_ff};
            mul_b = x2_ff;
         end
         ST_RECIP: begin
            mul_a = prod_ff[61:30];
            mul_b = {2'd0, recip_of(step_ff[2:0])};
         end
         ST_CORR: begin
            mul_a = prod_ff[63:32];
            mul_b = {24'd0, divisor_of(step_ff[2:0])};
         end
         ST_MUL_R: begin
            mul_a = {24'd0, red_ff};
            mul_b = {19'd0, gain_ff};
         end
         ST_MUL_G: begin
            mul_a = {24'd0, green_ff};
            mul_b = {19'd0, gain_ff};
         end
         ST_MUL_B: begin
            mul_a = {24'd0, blue_ff};
            mul_b = {19'd0, gain_ff};
         end
         default: mul_en = 1'b0;
      endcase
   end

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      idx_in       = idx_ff;
      now_in       = now_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      diff_in      = diff_ff;
      rem_in       = rem_ff;
      per_in       = per_ff;
      q_in         = q_ff;
      step_in      = step_ff;
      x_in         = x_ff;
      x2_in        = x2_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;
      n_in         = n_ff;
      qe_in        = qe_ff;
      gain_in      = gain_ff;
      rsp_red_in   = rsp_red_ff;
      rsp_green_in = rsp_green_ff;
      rsp_blue_in  = rsp_blue_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mem_we       = 1'b0;
      mem_wa       = idx_ff;
      mem_wd       = '0;
      mem_re       = 1'b0;

      case (state_ff)
         // Clearing pass over the fade table
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(LED_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         // Take a request
         ST_IDLE: begin
            if (req_accept) begin
               idx_in   = req_led[IDX_W-1:0];
               now_in   = req_now;
               red_in   = req_tdata[RED_LO +: CHAN_W];
               green_in = req_tdata[GREEN_LO +: CHAN_W];
               blue_in  = req_tdata[BLUE_LO +: CHAN_W];
               if (req_tuser == KIND_START) begin
                  if (req_in_range) begin
                     mem_we = 1'b1;
                     mem_wa = req_led[IDX_W-1:0];
                     mem_wd.last_tick       = req_now;
                     mem_wd.period_ticks    = req_period;
                     mem_wd.remaining_ticks = req_period;
                  end
               end else if (req_in_range) begin
                  mem_re   = 1'b1;
                  state_in = ST_FETCH;
               end else begin
                  gain_in  = GAIN_ONE;
                  state_in = ST_OUTWAIT;
               end
            end
         end
         // Entry read back: elapsed ticks
         ST_FETCH: begin
            diff_in  = now_ff - rd_ff.last_tick;
            rem_in   = rd_ff.remaining_ticks;
            per_in   = rd_ff.period_ticks;
            state_in = ST_UPDATE;
         end
         // Age the entry, stopping at zero, and write it back
         ST_UPDATE: begin
            rem_in = age_diff[TIME_W] ? '0 : age_diff[TIME_W-1:0];
            mem_we = 1'b1;
            mem_wa = idx_ff;
            mem_wd.last_tick       = now_ff;
            mem_wd.period_ticks    = per_ff;
            mem_wd.remaining_ticks = rem_in;
            state_in = ST_RANGE;
         end
         // Special cases ahead of the fraction divide
         ST_RANGE: begin
            q_in    = '0;
            step_in = '0;
            if (per_ff == '0) begin
               gain_in  = '0;
               state_in = ST_OUTWAIT;
            end else if (rem_ff >= per_ff) begin
               q_in     = (FRAC_W + 1)'(1) << FRAC_W;
               state_in = ST_ANGLE;
            end else begin
               state_in = ST_DIV;
            end
         end
         // Restoring divide, one fraction bit per cycle
         ST_DIV: begin
            q_in    = {q_ff[FRAC_W-1:0], !div_trial[TIME_W]};
            rem_in  = div_trial[TIME_W] ? {rem_ff[TIME_W-2:0], 1'b0} :
                                          div_trial[TIME_W-1:0];
            step_in = step_ff + 1'b1;
            if (step_ff == 4'(FRAC_W - 1)) begin
               state_in = ST_ANGLE;
            end
         end
         ST_ANGLE: state_in = ST_ROUND;
         // Angle in Q30, rounded
         ST_ROUND: begin
            x_in     = angle_rnd[40:10];
            state_in = ST_SQUARE;
         end
         ST_SQUARE: state_in = ST_SQSAVE;
         // Series start: sum = term = x
         ST_SQSAVE: begin
            x2_in    = prod_ff[61:30];
            term_in  = x_ff;
            sum_in   = {1'b0, x_ff};
            step_in  = 4'd1;
            state_in = ST_TERM;
         end
         ST_TERM: state_in = ST_RECIP;
         // Dividend of the term, quotient estimate issued
         ST_RECIP: begin
            n_in     = prod_ff[61:30];
            state_in = ST_CORR;
         end
         ST_CORR: begin
            qe_in    = prod_ff[61:32];
            state_in = ST_FIX;
         end
         // Quotient correction and alternating accumulate
         ST_FIX: begin
            term_in = {1'b0, corr_q};
            if (step_ff[0]) begin
               sum_in = sum_ff - {2'd0, corr_q};
            end else begin
               sum_in = sum_ff + {2'd0, corr_q};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 4'd7) begin
               state_in = ST_GAIN;
            end else begin
               state_in = ST_TERM;
            end
         end
         // Round to Q12 and cap at unity
         ST_GAIN: begin
            gain_in  = (gain_raw > {2'd0, GAIN_ONE}) ? GAIN_ONE : gain_raw[GAIN_W-1:0];
            state_in = ST_OUTWAIT;
         end
         // Output register must be free before the colour is scaled into it
         ST_OUTWAIT: begin
            if (slot_free) begin
               state_in = ST_MUL_R;
            end
         end
         ST_MUL_R: state_in = ST_MUL_G;
         ST_MUL_G: begin
            rsp_red_in = prod_ff[19:12];
            state_in   = ST_MUL_B;
         end
         ST_MUL_B: begin
            rsp_green_in = prod_ff[19:12];
            state_in     = ST_MUL_END;
         end
         ST_MUL_END: begin
            rsp_blue_in  = prod_ff[19:12];
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      now_ff       <= now_in;
      red_ff       <= red_in;
      green_ff     <= green_in;
      blue_ff      <= blue_in;
      diff_ff      <= diff_in;
      rem_ff       <= rem_in;
      per_ff       <= per_in;
      q_ff         <= q_in;
      x_ff         <= x_in;
      x2_ff        <= x2_in;
      term_ff      <= term_in;
      sum_ff       <= sum_in;
      n_ff         <= n_in;
      qe_ff        <= qe_in;
      gain_ff      <= gain_in;
      rsp_red_ff   <= rsp_red_in;
      rsp_green_ff <= rsp_green_in;
      rsp_blue_ff  <= rsp_blue_in;
   end

   // Shared multiplier, product registered
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= {32'd0, mul_a} * {32'd0, mul_b};
      end
   end

   // Fade table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= mem[req_led[IDX_W-1:0]];
      end
   end

   // No request is taken during the clearing pass
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("request taken while fade table clears");

   // Divider remainder stays below the period
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < per_ff))
      else $error("fraction divider remainder out of range");

   // Series index stays within the seven terms
   a_term_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TERM || state_ff == ST_RECIP || state_ff == ST_CORR ||
       state_ff == ST_FIX) |-> (step_ff >= 4'd1 && step_ff <= 4'd7))
      else $error("series term index out of range");

   // A response only appears at the end of the colour scaling
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_MUL_END))
      else $error("response raised outside colour scaling");

   // Gain never exceeds unity while scaling
   a_gain_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_R) |-> (gain_ff <= GAIN_ONE))
      else $error("gain above unity");

endmodule

`default_nettype wire

FILE: tb/tb_per_led_sine_fade_out.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_per_led_sine_fade_out: self-checking bench for the per-LED sine fade-out
// Drives start and execute requests with random gaps on both channels, keeps
// its own fade table and fixed-point sine gain, and compares every colour
// response field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module tb_per_led_sine_fade_out;
   import plsf_pkg::*;

   localparam int          LED_N         = 16;
   localparam int          MAX_GAP       = 19;
   localparam int          SETTLE_CYCLES = 80;
   localparam int unsigned CYCLE_LIMIT   = 1_000_000;

   // red in the lowest byte, as on rsp_tdata
   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } colour_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = KIND_START;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Fade table as the bench expects it to be
   logic [TIME_W-1:0] fade_left  [LED_N];
   logic [TIME_W-1:0] fade_len   [LED_N];
   logic [TIME_W-1:0] fade_stamp [LED_N];

   colour_type  expected_colours[$];
   bit          req_idle = 1'b1;
   bit          rsp_idle = 1'b1;
   int          mismatch_count    = 0;
   int          starts_sent       = 0;
   int          executes_sent     = 0;
   int          outside_sent      = 0;
   int          responses_checked = 0;
   int unsigned cycle_count       = 0;

   per_led_sine_fade_out #(.LED_COUNT(LED_N)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial forever #5 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_colours.size());
         $display("tb_per_led_sine_fade_out: FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] mismatch %0d: %s", $time, mismatch_count, msg);
   endtask

   // floor(rem * 2^FRAC_W / len), saturating at unity; len nonzero
   function automatic logic [FRAC_W:0] fade_fraction(input logic [TIME_W-1:0] rem,
                                                     input logic [TIME_W-1:0] len);
      bit [63:0]       r;
      bit [63:0]       p;
      logic [FRAC_W:0] q;
      r = 64'(rem);
      p = 64'(len);
      q = '0;
      if (r >= p) return (FRAC_W+1)'(1) << FRAC_W;
      for (int i = 0; i < FRAC_W; i++) begin
         q = q << 1;
         if (r >= p - r) begin
            r = r - (p - r);
            q[0] = 1'b1;
         end else begin
            r = r << 1;
         end
      end
      return q;
   endfunction

   // Taylor sine in Q30 up to the x^15 term, rounded to a 4096-based gain
   function automatic logic [GAIN_W-1:0] fade_gain(input logic [FRAC_W:0] q);
      bit [63:0] x;
      bit [63:0] x2;
      bit [63:0] term;
      bit [63:0] acc;
      x    = (64'(q) * 64'(PI_HALF_Q30) + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
      x2   = (x * x) >> 30;
      term = x;
      acc  = x;
      for (int k = 1; k <= 7; k++) begin
         term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) acc = acc - term;
         else            acc = acc + term;
      end
      acc = (acc + (64'd1 << 17)) >> 18;
      return (acc > 64'(GAIN_ONE)) ? GAIN_ONE : acc[GAIN_W-1:0];
   endfunction

   function automatic logic [CHAN_W-1:0] scale_colour(input logic [CHAN_W-1:0] c,
                                                      input logic [GAIN_W-1:0] g);
      logic [20:0] prod;
      prod = 21'(c) * 21'(g);
      return prod[19:12];
   endfunction

   // Update the expected table for one accepted request, queue an execute's colour
   task automatic apply_request(input logic kind, input logic [LED_W-1:0] led,
                                input logic [TIME_W-1:0] period,
                                input logic [TIME_W-1:0] now, input colour_type c);
      logic [TIME_W-1:0] elapsed;
      logic [GAIN_W-1:0] gain;
      colour_type        res;
      if (led >= LED_N) outside_sent++;
      if (kind == KIND_START) begin
         starts_sent++;
         if (led < LED_N) begin
            fade_left[led]  = period;
            fade_len[led]   = period;
            fade_stamp[led] = now;
         end
      end else begin
         executes_sent++;
         gain = GAIN_ONE;
         if (led < LED_N) begin
            elapsed = now - fade_stamp[led];
            fade_left[led]  = (elapsed > fade_left[led]) ? '0 : fade_left[led] - elapsed;
            fade_stamp[led] = now;
            gain = (fade_len[led] == '0) ? '0
                 : fade_gain(fade_fraction(fade_left[led], fade_len[led]));
         end
         res.red   = scale_colour(c.red, gain);
         res.green = scale_colour(c.green, gain);
         res.blue  = scale_colour(c.blue, gain);
         expected_colours.push_back(res);
      end
   endtask

   // Present one request, after a random gap when req_idle is set, and hold it until taken
   task automatic send_request(input logic kind, input logic [LED_W-1:0] led,
                               input logic [TIME_W-1:0] period,
                               input logic [TIME_W-1:0] now, input colour_type c);
      int gap;
      gap = req_idle ? $urandom_range(0, MAX_GAP) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {c.blue, c.green, c.red, now, period, led};
      do @(posedge clock); while (!req_tready);
      apply_request(kind, led, period, now, c);
   endtask

   function automatic colour_type random_colour();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) return '1;
      if (pick < 15) return '0;
      return colour_type'(24'($urandom));
   endfunction

   // Withdraw the held request, then wait for every outstanding response
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_colours.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Response side: random stalls when rsp_idle is set, check each colour against the oldest prediction
   initial begin
      colour_type got;
      colour_type want;
      int         stall;
      wait (reset == 1'b0);
      forever begin
         stall = rsp_idle ? $urandom_range(0, MAX_GAP) : 0;
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got = colour_type'(rsp_tdata);
         if (expected_colours.size() == 0) begin
            report_mismatch($sformatf("response %h with nothing outstanding", got));
         end else begin
            want = expected_colours.pop_front();
            responses_checked++;
            if (got.red !== want.red)
               report_mismatch($sformatf("red got %0d, expected %0d", got.red, want.red));
            if (got.green !== want.green)
               report_mismatch($sformatf("green got %0d, expected %0d",
                                         got.green, want.green));
            if (got.blue !== want.blue)
               report_mismatch($sformatf("blue got %0d, expected %0d",
                                         got.blue, want.blue));
         end
      end
   end

   // Cleared table gives black; out-of-range starts are dropped, executes pass through
   task automatic test_cleared_table();
      send_request(KIND_EXEC,  16'd0,     32'd0,   32'd0,   '1);
      send_request(KIND_EXEC,  16'd7,     32'd77,  32'd500, colour_type'(24'h80_40_FF));
      send_request(KIND_EXEC,  16'd15,    32'd0,   32'hFFFF_FFFF, '1);
      send_request(KIND_START, 16'd16,    32'd100, 32'd3,   '0);
      send_request(KIND_START, 16'hFFFF,  32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
      send_request(KIND_EXEC,  16'd16,    32'd0,   32'd9,   colour_type'(24'h01_80_FF));
      send_request(KIND_EXEC,  16'hFFFF,  32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
   endtask

   // Full, partial and expired fades, tick wrap, zero and unit periods
   task automatic test_fade_extremes();
      send_request(KIND_START, 16'd0,  32'd1000, 32'd100, '0);
      send_request(KIND_EXEC,  16'd0,  32'd0,    32'd100, '1);
      send_request(KIND_EXEC,  16'd0,  32'd0,    32'd600, '1);
      send_request(KIND_EXEC,  16'd0,  32'd0,    32'd850, colour_type'(24'h01_80_FF));
      send_request(KIND_EXEC,  16'd0,  32'd0,    32'd5000, '1);
      send_request(KIND_START, 16'd15, 32'hFFFF_FFFF, 32'hFFFF_FFF0, '0);
      send_request(KIND_EXEC,  16'd15, 32'd0,    32'h0000_0010, '1);
      send_request(KIND_EXEC,  16'd15, 32'd0,    32'h8000_0000, '1);
      send_request(KIND_START, 16'd3,  32'd0,    32'd50,  '1);
      send_request(KIND_EXEC,  16'd3,  32'd0,    32'd60,  '1);
      send_request(KIND_START, 16'd5,  32'd1,    32'd7,   '0);
      send_request(KIND_EXEC,  16'd5,  32'd0,    32'd7,   '1);
      send_request(KIND_EXEC,  16'd5,  32'd0,    32'd8,   '1);
      send_request(KIND_EXEC,  16'd0,  32'd0,    32'd9000, '0);
   endtask

   // Mostly well-formed fades with random timing, plus stray indices and random ticks
   task automatic test_random_fades(input int n_items);
      logic              kind;
      logic [LED_W-1:0]  led;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] now;
      longint unsigned   span;
      int                pick;
      int                mode;
      for (int i = 0; i < n_items; i++) begin
         // change the gap pattern every hundred requests
         if (i % 100 == 0) begin
            mode     = $urandom_range(0, 3);
            req_idle = (mode <= 1);
            rsp_idle = (mode == 0 || mode == 2);
         end
         // hold off once until every response is back
         if (i == n_items / 2) wait_drained();
         pick   = $urandom_range(0, 99);
         led    = (pick < 8) ? LED_W'($urandom_range(LED_N, 65535))
                             : LED_W'($urandom_range(0, LED_N - 1));
         kind   = ($urandom_range(0, 99) < 22) ? KIND_START : KIND_EXEC;
         period = $urandom;
         now    = $urandom;
         if (led < LED_N) begin
            pick = $urandom_range(0, 99);
            if (kind == KIND_START) begin
               if (pick < 5)       period = '0;
               else if (pick < 45) period = $urandom_range(1, 64);
               else if (pick < 80) period = $urandom_range(65, 100000);
               if ($urandom_range(0, 9) != 0)
                  now = fade_stamp[led] + TIME_W'($urandom_range(0, 5000));
            end else begin
               span = 64'(fade_len[led]);
               if (pick < 10) begin
                  now = fade_stamp[led];
               end else if (pick < 70) begin
                  now = fade_stamp[led] + TIME_W'($urandom_range(0, 32'(span / 8)));
               end else if (pick < 85) begin
                  span = span + span / 4 + 1;
                  if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
                  now = fade_stamp[led] + TIME_W'($urandom_range(0, 32'(span)));
               end
            end
         end
         send_request(kind, led, period, now, random_colour());
      end
   endtask

   initial begin
      for (int i = 0; i < LED_N; i++) begin
         fade_left[i]  = '0;
         fade_len[i]   = '0;
         fade_stamp[i] = '0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_cleared_table();
      test_fade_extremes();
      wait_drained();
      test_random_fades(1430);

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait_drained();
      if (expected_colours.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", expected_colours.size()));

      $display("Covered %0d start and %0d execute requests, %0d aimed at absent LEDs.",
               starts_sent, executes_sent, outside_sent);
      $display("Checked %0d colour responses in %0d cycles, %0d mismatches.",
               responses_checked, cycle_count, mismatch_count);
      if (mismatch_count == 0)
         $display("tb_per_led_sine_fade_out: PASS");
      else
         $display("tb_per_led_sine_fade_out: FAIL");
      $finish;
   end

endmodule
